### rtl/fpd_pkg.sv
// Shared types and constants for the fractional phase delay core.
// No dependencies; imported by fractional_phase_delay_core.
package fpd_pkg;

    // Default widths of the sample path and the phase register
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int PHASE_WIDTH_DEF  = 16;

    // Period word: unsigned 16.8 fixed point
    localparam int PERIOD_WIDTH = 24;
    localparam int PERIOD_FRAC  = 8;

    // Whole-sample shift, skip count and Q.16 fraction weight
    localparam int SHIFT_WIDTH  = PERIOD_WIDTH - PERIOD_FRAC + 1;
    localparam int SKIP_WIDTH   = SHIFT_WIDTH + 1;
    localparam int WEIGHT_WIDTH = 16;

    localparam int FUNC_WIDTH = 2;

    typedef enum logic [FUNC_WIDTH-1:0] {
        FUNC_PLUS   = 2'b00,
        FUNC_MINUS  = 2'b01,
        FUNC_PERIOD = 2'b10
    } func_t;

    typedef enum logic {
        CHANNEL_PLUS  = 1'b0,
        CHANNEL_MINUS = 1'b1
    } channel_t;

endpackage

### rtl/fractional_phase_delay_core.sv
// Fractional phase delay core: two-channel phase shifter with skip and interpolation.
// Depends on fpd_pkg. An accepted item is registered in the item stage, then its result
// in the result register. Throughput: one item per cycle while neither result_stall nor
// a register write holds the item stage (shift recompute: 16x24 multiply, saturating add).
// Reset: asynchronous, active low; clears the phase, period, shift, skip count,
// fraction weight and both held samples.
module fractional_phase_delay_core #(
    parameter int SAMPLE_WIDTH = fpd_pkg::SAMPLE_WIDTH_DEF,
    parameter int PHASE_WIDTH  = fpd_pkg::PHASE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input item channel
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [fpd_pkg::FUNC_WIDTH-1:0]       func,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
    input  logic [fpd_pkg::PERIOD_WIDTH-1:0]     period_value,
    // result item channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic                                 channel,
    output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
    // phase offset register write
    input  logic                                 cfg_write,
    input  logic signed [PHASE_WIDTH-1:0]        cfg_data
);

    import fpd_pkg::*;

    // Product of phase and period carries FRAC_BITS fraction bits
    localparam int PROD_WIDTH = PHASE_WIDTH + PERIOD_WIDTH + 1;
    localparam int FRAC_BITS  = PHASE_WIDTH + PERIOD_FRAC;
    localparam logic [PROD_WIDTH-1:0] PROD_HALF = PROD_WIDTH'(1) << (FRAC_BITS - 1);

    // Interpolation product: difference times weight (weight up to one half turn)
    localparam int DIFF_WIDTH = SAMPLE_WIDTH + 1;
    localparam int MIX_WIDTH  = DIFF_WIDTH + WEIGHT_WIDTH + 1;
    localparam logic [MIX_WIDTH-1:0] MIX_HALF = MIX_WIDTH'(1) << (WEIGHT_WIDTH - 1);

    localparam logic signed [SKIP_WIDTH-1:0] SKIP_MAX = {1'b0, {(SKIP_WIDTH-1){1'b1}}};
    localparam logic signed [SKIP_WIDTH-1:0] SKIP_MIN = {1'b1, {(SKIP_WIDTH-1){1'b0}}};
    localparam logic signed [SKIP_WIDTH-1:0] SKIP_ONE = SKIP_WIDTH'(1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    // item stage
    logic                              s1_valid_reg, s1_valid_next;
    logic [FUNC_WIDTH-1:0]             s1_func_reg;
    logic signed [SAMPLE_WIDTH-1:0]    s1_sample_reg;
    logic [PERIOD_WIDTH-1:0]           s1_period_reg;

    // configuration and shift state
    logic signed [PHASE_WIDTH-1:0]     phase_reg;
    logic                              recompute_req_reg, recompute_req_next;
    logic [PERIOD_WIDTH-1:0]           period_reg, period_next;
    logic signed [SHIFT_WIDTH-1:0]     shift_reg, shift_next;
    logic signed [SKIP_WIDTH-1:0]      skip_reg, skip_next;
    logic signed [WEIGHT_WIDTH-1:0]    weight_reg, weight_next;

    // lookahead samples of each channel
    logic signed [SAMPLE_WIDTH-1:0]    held_plus_reg, held_plus_next;
    logic signed [SAMPLE_WIDTH-1:0]    held_minus_reg, held_minus_next;
    logic                              plus_valid_reg, plus_valid_next;
    logic                              minus_valid_reg, minus_valid_next;

    // result register
    logic                              result_valid_reg, result_valid_next;
    logic                              channel_reg, channel_next;
    logic signed [SAMPLE_WIDTH-1:0]    sample_out_reg, sample_out_next;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic item_accept;
    logic advance;
    logic item_go;

    // The result register takes a new value when it is empty or being drained.
    assign advance = !result_valid_reg || !result_stall;
    // A pending recompute owns the shift state; hold the item stage.
    assign item_go     = s1_valid_reg && advance && !recompute_req_reg;
    assign item_stall  = s1_valid_reg && !item_go;
    assign item_accept = item_valid && !item_stall;

    // ------------------------------------------------------------------
    // Shift recompute: prod = phase * period, round half up to whole samples
    // ------------------------------------------------------------------
    logic [PERIOD_WIDTH-1:0]           period_src;
    logic signed [PROD_WIDTH-1:0]      prod;
    logic signed [PROD_WIDTH-1:0]      prod_rnd;
    logic signed [SHIFT_WIDTH-1:0]     shift_new;
    logic signed [WEIGHT_WIDTH-1:0]    weight_new;
    logic signed [SKIP_WIDTH:0]        skip_sum;
    logic signed [SKIP_WIDTH-1:0]      skip_sat;

    assign period_src = recompute_req_reg ? period_reg : s1_period_reg;
    assign prod       = $signed(phase_reg) * $signed({1'b0, period_src});
    assign prod_rnd   = prod + $signed(PROD_HALF);
    // Arithmetic shift right by FRAC_BITS: the upper bits are the rounded shift.
    assign shift_new  = prod_rnd[PROD_WIDTH-1:FRAC_BITS];
    // Remainder is the low field minus one half; its top 16 bits with the
    // sign bit flipped give the floored Q.16 weight.
    assign weight_new = {~prod_rnd[FRAC_BITS-1],
                         prod_rnd[FRAC_BITS-2:FRAC_BITS-WEIGHT_WIDTH]};

    // Add the change of the whole shift to the skip count, saturating.
    assign skip_sum = {skip_reg[SKIP_WIDTH-1], skip_reg}
                    + {{2{shift_new[SHIFT_WIDTH-1]}}, shift_new}
                    - {{2{shift_reg[SHIFT_WIDTH-1]}}, shift_reg};

    always_comb
    begin
        if (skip_sum[SKIP_WIDTH] != skip_sum[SKIP_WIDTH-1])
        begin
            skip_sat = skip_sum[SKIP_WIDTH] ? SKIP_MIN : SKIP_MAX;
        end
        else
        begin
            skip_sat = skip_sum[SKIP_WIDTH-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Interpolation: held + round((new - held) * w / 2^16)
    // ------------------------------------------------------------------
    logic                              is_minus;
    logic signed [SAMPLE_WIDTH-1:0]    held_sel;
    logic [WEIGHT_WIDTH-1:0]           w_plus;
    logic [WEIGHT_WIDTH-1:0]           w_minus;
    logic [WEIGHT_WIDTH-1:0]           w_sel;
    logic signed [DIFF_WIDTH-1:0]      diff;
    logic signed [MIX_WIDTH-1:0]       mix_prod;
    logic signed [MIX_WIDTH-1:0]       mix_rnd;
    logic signed [SAMPLE_WIDTH-1:0]    mix_out;

    assign is_minus = (s1_func_reg == FUNC_MINUS);
    assign held_sel = is_minus ? held_minus_reg : held_plus_reg;

    // Positive weight acts on plus, negative weight on minus, else pass through.
    assign w_plus  = weight_reg[WEIGHT_WIDTH-1] ? '0 : weight_reg;
    assign w_minus = weight_reg[WEIGHT_WIDTH-1] ? WEIGHT_WIDTH'(-weight_reg) : '0;
    assign w_sel   = is_minus ? w_minus : w_plus;

    assign diff     = {s1_sample_reg[SAMPLE_WIDTH-1], s1_sample_reg}
                    - {held_sel[SAMPLE_WIDTH-1], held_sel};
    assign mix_prod = diff * $signed({1'b0, w_sel});
    assign mix_rnd  = mix_prod + $signed(MIX_HALF);
    // Result lies between held and new sample, so the low bits are exact.
    assign mix_out  = held_sel + mix_rnd[WEIGHT_WIDTH+SAMPLE_WIDTH-1:WEIGHT_WIDTH];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    logic produce;
    logic held_valid_sel;
    logic drop;

    assign held_valid_sel = is_minus ? minus_valid_reg : plus_valid_reg;

    always_comb
    begin
        period_next       = period_reg;
        shift_next        = shift_reg;
        skip_next         = skip_reg;
        weight_next       = weight_reg;
        held_plus_next    = held_plus_reg;
        held_minus_next   = held_minus_reg;
        plus_valid_next   = plus_valid_reg;
        minus_valid_next  = minus_valid_reg;
        produce           = 1'b0;
        drop              = 1'b0;
        channel_next      = is_minus ? CHANNEL_MINUS : CHANNEL_PLUS;
        sample_out_next   = mix_out;
        recompute_req_next = cfg_write;

        // Recompute after a register write, ahead of any item
        if (recompute_req_reg)
        begin
            period_next = period_src;
            shift_next  = shift_new;
            weight_next = weight_new;
            skip_next   = skip_sat;
        end
        else if (item_go)
        begin
            unique case (s1_func_reg)
                FUNC_PERIOD:
                begin
                    period_next = period_src;
                    shift_next  = shift_new;
                    weight_next = weight_new;
                    skip_next   = skip_sat;
                end
                FUNC_PLUS, FUNC_MINUS:
                begin
                    drop = is_minus ? skip_reg[SKIP_WIDTH-1]
                                    : (!skip_reg[SKIP_WIDTH-1] && (skip_reg != '0));
                    if (drop)
                    begin
                        // Drop: move the count one toward zero, replace held sample if one is held
                        skip_next = is_minus ? skip_reg + SKIP_ONE : skip_reg - SKIP_ONE;
                        if (held_valid_sel)
                        begin
                            if (is_minus)
                            begin
                                held_minus_next = s1_sample_reg;
                            end
                            else
                            begin
                                held_plus_next = s1_sample_reg;
                            end
                        end
                    end
                    else
                    begin
                        produce = held_valid_sel;
                        if (is_minus)
                        begin
                            held_minus_next  = s1_sample_reg;
                            minus_valid_next = 1'b1;
                        end
                        else
                        begin
                            held_plus_next  = s1_sample_reg;
                            plus_valid_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // unused code: no state change, no result
                end
            endcase
        end
    end

    assign s1_valid_next     = item_accept ? 1'b1 : (item_go ? 1'b0 : s1_valid_reg);
    assign result_valid_next = advance ? produce : result_valid_reg;

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            phase_reg         <= '0;
            recompute_req_reg <= 1'b0;
            period_reg        <= '0;
            shift_reg         <= '0;
            skip_reg          <= '0;
            weight_reg        <= '0;
            held_plus_reg     <= '0;
            held_minus_reg    <= '0;
            plus_valid_reg    <= 1'b0;
            minus_valid_reg   <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            recompute_req_reg <= recompute_req_next;
            if (cfg_write)
            begin
                phase_reg <= cfg_data;
            end
            period_reg        <= period_next;
            shift_reg         <= shift_next;
            skip_reg          <= skip_next;
            weight_reg        <= weight_next;
            held_plus_reg     <= held_plus_next;
            held_minus_reg    <= held_minus_next;
            plus_valid_reg    <= plus_valid_next;
            minus_valid_reg   <= minus_valid_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: item stage and result
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_func_reg   <= func;
            s1_sample_reg <= sample_in;
            s1_period_reg <= period_value;
        end
        if (advance && produce)
        begin
            channel_reg    <= channel_next;
            sample_out_reg <= sample_out_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign channel      = channel_reg;
    assign sample_out   = sample_out_reg;

endmodule
